// File: src/iate_pkg.sv
// Package for the indexed array table engine: opcodes, status codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package iate_pkg;

  localparam int unsigned OpcodeWidth = 4;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned FoundWidth  = 7;
  localparam int unsigned CountWidth  = 8;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_CLEAR  = 4'd0,
    OP_INSERT = 4'd1,
    OP_UPDATE = 4'd2,
    OP_DELETE = 4'd3,
    OP_SORTA  = 4'd4,
    OP_SORTD  = 4'd5,
    OP_LFIND  = 4'd6,
    OP_BFIND  = 4'd7,
    OP_READ   = 4'd8
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_MISS   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_RD,   // read source entry for insert/delete shift
    S_SHIFT_WR,   // write it one place over
    S_WRITE,      // write item value at position
    S_SORT_RDI,   // read entry i
    S_SORT_RDJ,   // read entry j
    S_SORT_CMP,   // compare, maybe write j
    S_SORT_WRI,   // write entry i
    S_LIN_RD,
    S_LIN_CMP,
    S_BIN_RD,
    S_BIN_CMP,
    S_READ_RD,
    S_READ_CAP,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       latch_item;   // capture input item
    logic       setup;        // load loop registers from the decoded op
    logic       mem_re;       // read at rd_sel address
    logic [1:0] rd_sel;       // 0 idx, 1 idx_b (j), 2 mid (pos for read)
    logic       mem_we;
    logic [1:0] wr_sel;       // address: 0 idx, 1 idx_b, 2 pos ; data below
    logic [1:0] wd_sel;       // data: 0 item value, 1 read data, 2 hold_a
    logic       cap_a;        // capture read data into hold_a
    logic       step;         // advance the active loop
    logic       bin_step;     // apply halving step
    logic       set_result;   // finalize status from cond flags
    logic       cap_read;     // capture read data as result
    logic       out_load;     // load output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    opcode_e op;
    logic    full;         // count at capacity
    logic    bad_ins;      // insert position past end
    logic    bad_pos;      // position >= count
    logic    loop_done;    // active loop index exhausted
    logic    inner_done;   // sort inner index exhausted
    logic    outer_done;   // sort outer index exhausted
    logic    match;        // read data equals item value
    logic    swap;         // sort pair out of order
    logic    bin_done;     // left > right
  } stat_t;

endpackage

// File: src/iate_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface iate_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/indexed_array_table_engine.sv
// Top level of the indexed array table engine.
// Depends on iate_pkg, iate_if, iate_ctrl, iate_dp.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port RAM and answers each item with one result. One item is
// worked at a time, and the RAM port paces each operation: insert and
// delete shift entries one by one, linear find scans entry by entry,
// binary find halves its window per step, and a sort compares every
// pair. The next item is taken once the result sits in the output register.
`timescale 1ns / 1ps
module indexed_array_table_engine #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  iate_if.sink   in_i,
  iate_if.source out_o
);
  localparam int unsigned InW = iate_pkg::OpcodeWidth + iate_pkg::PosWidth
                                + iate_pkg::DataWidth;

  iate_pkg::cmd_t  cmd;
  iate_pkg::stat_t stat;
  logic            out_full;
  logic [iate_pkg::OpcodeWidth-1:0] opcode;
  logic [iate_pkg::PosWidth-1:0]    position;
  logic [iate_pkg::DataWidth-1:0]   value;
  logic [iate_pkg::StatusWidth-1:0] status;
  logic [iate_pkg::FoundWidth-1:0]  found_index;
  logic [iate_pkg::DataWidth-1:0]   read_data;
  logic [iate_pkg::CountWidth-1:0]  count;

  // payload: {opcode, position, value}
  assign opcode   = in_i.payload[InW-1 -: iate_pkg::OpcodeWidth];
  assign position = in_i.payload[iate_pkg::DataWidth +: iate_pkg::PosWidth];
  assign value    = in_i.payload[iate_pkg::DataWidth-1:0];
  assign out_o.payload = {status, found_index, read_data, count};

  iate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_full_i (out_full),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iate_dp #(.Capacity(CAPACITY)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode),
    .position_i    (position),
    .value_i       (value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_full_o    (out_full),
    .status_o      (status),
    .found_index_o (found_index),
    .read_data_o   (read_data),
    .count_o       (count)
  );
endmodule

// File: src/iate_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module iate_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

// File: src/iate_ctrl.sv
// Controller state machine for the table engine.
// Depends on iate_pkg.
`timescale 1ns / 1ps
module iate_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_full_i,
  input  iate_pkg::stat_t  stat_i,
  output iate_pkg::cmd_t   cmd_o
);
  iate_pkg::state_e state_q, state_d;
  logic             sort_first_q, sort_first_d;

  // Mark the first inner pass of a sort row, right after entry i is read
  assign sort_first_d = (state_q == iate_pkg::S_SORT_RDI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= iate_pkg::S_IDLE;
      sort_first_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      sort_first_q <= sort_first_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iate_pkg::S_IDLE: if (in_valid_i) state_d = iate_pkg::S_DECODE;
      iate_pkg::S_DECODE: begin
        case (stat_i.op)
          iate_pkg::OP_INSERT:
            if (stat_i.full || stat_i.bad_ins) state_d = iate_pkg::S_DONE;
            else if (stat_i.loop_done) state_d = iate_pkg::S_WRITE;
            else state_d = iate_pkg::S_SHIFT_RD;
          iate_pkg::OP_UPDATE:
            state_d = stat_i.bad_pos ? iate_pkg::S_DONE : iate_pkg::S_WRITE;
          iate_pkg::OP_DELETE:
            if (stat_i.bad_pos || stat_i.loop_done) state_d = iate_pkg::S_DONE;
            else state_d = iate_pkg::S_SHIFT_RD;
          iate_pkg::OP_SORTA, iate_pkg::OP_SORTD:
            state_d = stat_i.outer_done ? iate_pkg::S_DONE : iate_pkg::S_SORT_RDI;
          iate_pkg::OP_LFIND:
            state_d = stat_i.loop_done ? iate_pkg::S_DONE : iate_pkg::S_LIN_RD;
          iate_pkg::OP_BFIND:
            state_d = stat_i.bin_done ? iate_pkg::S_DONE : iate_pkg::S_BIN_RD;
          iate_pkg::OP_READ:
            state_d = stat_i.bad_pos ? iate_pkg::S_DONE : iate_pkg::S_READ_RD;
          default: state_d = iate_pkg::S_DONE;
        endcase
      end
      iate_pkg::S_SHIFT_RD: state_d = iate_pkg::S_SHIFT_WR;
      iate_pkg::S_SHIFT_WR: begin
        if (!stat_i.loop_done) state_d = iate_pkg::S_SHIFT_RD;
        else if (stat_i.op == iate_pkg::OP_INSERT) state_d = iate_pkg::S_WRITE;
        else state_d = iate_pkg::S_DONE;
      end
      iate_pkg::S_WRITE: state_d = iate_pkg::S_DONE;
      iate_pkg::S_SORT_RDI: state_d = iate_pkg::S_SORT_RDJ;
      iate_pkg::S_SORT_RDJ: state_d = iate_pkg::S_SORT_CMP;
      iate_pkg::S_SORT_CMP: begin
        if (!stat_i.inner_done) state_d = iate_pkg::S_SORT_RDJ;
        else state_d = iate_pkg::S_SORT_WRI;
      end
      iate_pkg::S_SORT_WRI:
        state_d = stat_i.outer_done ? iate_pkg::S_DONE : iate_pkg::S_SORT_RDI;
      iate_pkg::S_LIN_RD: state_d = iate_pkg::S_LIN_CMP;
      iate_pkg::S_LIN_CMP: begin
        if (stat_i.match || stat_i.loop_done) state_d = iate_pkg::S_DONE;
        else state_d = iate_pkg::S_LIN_RD;
      end
      iate_pkg::S_BIN_RD: state_d = iate_pkg::S_BIN_CMP;
      iate_pkg::S_BIN_CMP: begin
        if (stat_i.match || stat_i.bin_done) state_d = iate_pkg::S_DONE;
        else state_d = iate_pkg::S_BIN_RD;
      end
      iate_pkg::S_READ_RD: state_d = iate_pkg::S_READ_CAP;
      iate_pkg::S_READ_CAP: state_d = iate_pkg::S_DONE;
      iate_pkg::S_DONE: if (!out_full_i) state_d = iate_pkg::S_IDLE;
      default: state_d = iate_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      iate_pkg::S_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch_item = in_valid_i;
      end
      iate_pkg::S_DECODE: cmd_o.setup = 1'b1;
      iate_pkg::S_SHIFT_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd0;
      end
      iate_pkg::S_SHIFT_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = 2'd1;
        cmd_o.wd_sel = 2'd1;
        cmd_o.step   = 1'b1;
      end
      iate_pkg::S_WRITE: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = 2'd2;
        cmd_o.wd_sel = 2'd0;
      end
      iate_pkg::S_SORT_RDI: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd0;
      end
      iate_pkg::S_SORT_RDJ: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd1;
        cmd_o.cap_a  = sort_first_q;   // first pass grabs entry i; later passes keep
      end
      iate_pkg::S_SORT_CMP: begin
        // on swap: store hold_a at j, new hold_a from read data
        cmd_o.mem_we = stat_i.swap;
        cmd_o.wr_sel = 2'd1;
        cmd_o.wd_sel = 2'd2;
        cmd_o.cap_a  = stat_i.swap;
        cmd_o.step   = 1'b1;
      end
      iate_pkg::S_SORT_WRI: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = 2'd0;
        cmd_o.wd_sel = 2'd2;
        cmd_o.step   = 1'b1;
      end
      iate_pkg::S_LIN_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd0;
      end
      iate_pkg::S_LIN_CMP: cmd_o.step = 1'b1;
      iate_pkg::S_BIN_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd2;
      end
      iate_pkg::S_BIN_CMP: cmd_o.bin_step = 1'b1;
      iate_pkg::S_READ_RD: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_sel = 2'd2;
      end
      iate_pkg::S_READ_CAP: cmd_o.cap_read = 1'b1;
      iate_pkg::S_DONE: begin
        cmd_o.set_result = 1'b1;
        cmd_o.out_load   = !out_full_i;
      end
      default: ;
    endcase
  end
endmodule

// File: src/iate_dp.sv
// Datapath for the table engine: element RAM, count, loop indices,
// compare logic and result register. Depends on iate_pkg, iate_ram.
`timescale 1ns / 1ps
module iate_dp #(
  parameter int unsigned Capacity = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [iate_pkg::OpcodeWidth-1:0]   opcode_i,
  input  logic [iate_pkg::PosWidth-1:0]      position_i,
  input  logic [iate_pkg::DataWidth-1:0]     value_i,
  input  iate_pkg::cmd_t                     cmd_i,
  output iate_pkg::stat_t                    stat_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_full_o,
  output logic [iate_pkg::StatusWidth-1:0]   status_o,
  output logic [iate_pkg::FoundWidth-1:0]    found_index_o,
  output logic [iate_pkg::DataWidth-1:0]     read_data_o,
  output logic [iate_pkg::CountWidth-1:0]    count_o
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  // position field widened to compare against the count
  localparam int unsigned PW = (CW > iate_pkg::PosWidth) ? CW : iate_pkg::PosWidth;
  localparam int unsigned IW = CW + 1;   // signed loop index width

  logic [iate_pkg::OpcodeWidth-1:0] op_q;
  logic [PW-1:0]                    pos_q;
  logic [iate_pkg::DataWidth-1:0]   val_q;
  logic [CW-1:0]                    count_q, count_d;
  logic signed [IW-1:0]             idx_q, idx_d, idxb_q, idxb_d;
  logic signed [IW-1:0]             left_q, left_d, right_q, right_d;
  logic [iate_pkg::DataWidth-1:0]   hold_a_q, rdata;
  logic                             hit_q, hit_d;
  logic [CW-1:0]                    found_q, found_d;
  logic [iate_pkg::DataWidth-1:0]   rres_q;
  logic                             out_valid_q;
  logic [iate_pkg::StatusWidth-1:0] st_q;
  logic [iate_pkg::FoundWidth-1:0]  fo_q;
  logic [iate_pkg::DataWidth-1:0]   rd_q;
  logic [iate_pkg::CountWidth-1:0]  co_q;

  logic signed [IW-1:0] cnt_s, pos_s, mid, rd_addr, wr_addr;
  logic signed [IW:0]   mid_sum;
  logic [iate_pkg::DataWidth-1:0] wdata;
  logic less_rv, less_ar, mem_re, mem_we;
  logic [AW-1:0] addr;
  logic [CW-1:0] count_new;
  iate_pkg::status_e status_new;

  assign cnt_s   = IW'(count_q);
  assign pos_s   = (pos_q > PW'(Capacity)) ? IW'(Capacity) : IW'(pos_q);
  // midpoint of the halving window, sum kept one bit wider
  assign mid_sum = {left_q[IW-1], left_q} + {right_q[IW-1], right_q};
  assign mid     = mid_sum[IW:1];

  // Signed compares: read data vs. item value, hold_a vs. read data
  assign less_rv = $signed(rdata) < $signed(val_q);
  assign less_ar = $signed(hold_a_q) < $signed(rdata);

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q  <= opcode_i;
      pos_q <= PW'(position_i);
      val_q <= value_i;
    end
  end

  // Memory addressing
  always_comb begin
    case (cmd_i.rd_sel)
      2'd0:    rd_addr = idx_q;
      2'd1:    rd_addr = idxb_q;
      default: rd_addr = (op_q == iate_pkg::OP_READ) ? pos_s : mid;
    endcase
    case (cmd_i.wr_sel)
      2'd0:    wr_addr = idx_q;
      2'd1:    wr_addr = idxb_q;
      default: wr_addr = pos_s;
    endcase
    case (cmd_i.wd_sel)
      2'd0:    wdata = val_q;
      2'd1:    wdata = rdata;
      default: wdata = hold_a_q;
    endcase
  end
  // a swap write in the compare state stores hold_a at j
  assign mem_we = cmd_i.mem_we;
  assign mem_re = cmd_i.mem_re;
  assign addr   = mem_we ? wr_addr[AW-1:0] : rd_addr[AW-1:0];

  iate_ram #(.Width(iate_pkg::DataWidth), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Hold register: entry i during a sort pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      hold_a_q <= rdata;
    end
  end

  // Status to controller
  always_comb begin
    stat_o.op         = iate_pkg::opcode_e'(op_q);
    stat_o.full       = count_q >= CW'(Capacity);
    stat_o.bad_ins    = pos_q > PW'(count_q);
    stat_o.bad_pos    = pos_q >= PW'(count_q);
    stat_o.inner_done = idxb_d >= cnt_s;
    stat_o.outer_done = (idx_d + IW'(1)) >= cnt_s;
    stat_o.match      = rdata == val_q;
    stat_o.swap       = (op_q == iate_pkg::OP_SORTD) ? less_ar
                        : $signed(rdata) < $signed(hold_a_q);
    stat_o.bin_done   = left_d > right_d;
    // shift loops are judged on the destination index
    case (iate_pkg::opcode_e'(op_q))
      iate_pkg::OP_INSERT: stat_o.loop_done = idxb_d <= pos_s;
      iate_pkg::OP_DELETE: stat_o.loop_done = (idxb_d + IW'(1)) >= cnt_s;
      default:             stat_o.loop_done = idx_d >= cnt_s;
    endcase
  end

  // Loop registers
  always_comb begin
    idx_d   = idx_q;
    idxb_d  = idxb_q;
    left_d  = left_q;
    right_d = right_q;
    hit_d   = hit_q;
    found_d = found_q;
    if (cmd_i.setup) begin
      hit_d   = 1'b0;
      found_d = '0;
      left_d  = '0;
      right_d = cnt_s - IW'(1);
      case (iate_pkg::opcode_e'(op_q))
        // insert: idx is the source entry, idx_b its destination
        iate_pkg::OP_INSERT: begin
          idx_d  = cnt_s - IW'(1);
          idxb_d = cnt_s;
        end
        iate_pkg::OP_DELETE: begin
          idx_d  = pos_s + IW'(1);
          idxb_d = pos_s;
        end
        iate_pkg::OP_SORTA, iate_pkg::OP_SORTD: begin
          idx_d  = '0;
          idxb_d = IW'(1);
        end
        default: begin
          idx_d  = '0;
          idxb_d = '0;
        end
      endcase
    end else if (cmd_i.step) begin
      case (iate_pkg::opcode_e'(op_q))
        iate_pkg::OP_INSERT: begin
          idx_d  = idx_q - IW'(1);
          idxb_d = idxb_q - IW'(1);
        end
        iate_pkg::OP_DELETE: begin
          idx_d  = idx_q + IW'(1);
          idxb_d = idxb_q + IW'(1);
        end
        iate_pkg::OP_SORTA, iate_pkg::OP_SORTD: begin
          if (cmd_i.mem_we && cmd_i.wr_sel == 2'd0) begin
            idx_d  = idx_q + IW'(1);
            idxb_d = idx_q + IW'(2);
          end else begin
            idxb_d = idxb_q + IW'(1);
          end
        end
        default: begin
          if (rdata == val_q) begin
            hit_d   = 1'b1;
            found_d = CW'(idx_q);
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      endcase
    end else if (cmd_i.bin_step) begin
      if (rdata == val_q) begin
        hit_d   = 1'b1;
        found_d = CW'(mid);
      end else if (less_rv) begin
        left_d = mid + IW'(1);
      end else begin
        right_d = mid - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    idxb_q  <= idxb_d;
    left_q  <= left_d;
    right_q <= right_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    if (cmd_i.cap_read) begin
      rres_q <= rdata;
    end
    if (cmd_i.setup) begin
      rres_q <= '0;
    end
  end

  // Result and new count
  always_comb begin
    status_new = iate_pkg::ST_OK;
    count_new  = count_q;
    case (iate_pkg::opcode_e'(op_q))
      iate_pkg::OP_CLEAR:  count_new = '0;
      iate_pkg::OP_INSERT: begin
        if (count_q >= CW'(Capacity)) status_new = iate_pkg::ST_FULL;
        else if (pos_q > PW'(count_q)) status_new = iate_pkg::ST_BADPOS;
        else count_new = count_q + CW'(1);
      end
      iate_pkg::OP_UPDATE, iate_pkg::OP_READ:
        if (pos_q >= PW'(count_q)) status_new = iate_pkg::ST_BADPOS;
      iate_pkg::OP_DELETE: begin
        if (pos_q >= PW'(count_q)) status_new = iate_pkg::ST_BADPOS;
        else count_new = count_q - CW'(1);
      end
      iate_pkg::OP_LFIND, iate_pkg::OP_BFIND:
        if (!hit_q) status_new = iate_pkg::ST_MISS;
      default: ;
    endcase
  end

  assign count_d = cmd_i.out_load ? count_new : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      st_q <= status_new;
      fo_q <= hit_q ? iate_pkg::FoundWidth'(found_q) : '0;
      rd_q <= (op_q == iate_pkg::OP_READ && pos_q < PW'(count_q)) ? rres_q : '0;
      co_q <= iate_pkg::CountWidth'(count_new);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_full_o    = out_valid_q && !out_ready_i;
  assign status_o      = st_q;
  assign found_index_o = fo_q;
  assign read_data_o   = rd_q;
  assign count_o       = co_q;
endmodule

// File: verif/indexed_array_table_engine_tb.sv
// Testbench for indexed_array_table_engine: drives random and directed list
// operations and checks every result against a behavioral list predictor.
// Depends on iate_pkg, iate_if and the engine RTL.
`timescale 1ns / 1ps
module indexed_array_table_engine_tb;
  import iate_pkg::*;

  localparam int unsigned Cap = 128;
  localparam int InW = OpcodeWidth + PosWidth + DataWidth;
  localparam int OutW = StatusWidth + FoundWidth + DataWidth + CountWidth;
  localparam int IdleLimit = 200000;

  typedef struct packed {
    logic [OpcodeWidth-1:0] opcode;
    logic [PosWidth-1:0]    position;
    logic [DataWidth-1:0]   value;
  } cmd_item_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [FoundWidth-1:0]  found_index;
    logic [DataWidth-1:0]   read_data;
    logic [CountWidth-1:0]  count;
  } res_item_t;

  // List predictor plus queue of pending answers
  class list_scoreboard;
    logic signed [31:0] entries [Cap];
    int unsigned        fill;
    res_item_t          pending [$];
    int                 errors;

    function void note_command(cmd_item_t c);
      res_item_t r;
      int signed lo, hi, mid;
      logic signed [31:0] t;
      r = '0;
      r.status = ST_OK;
      case (c.opcode)
        OP_CLEAR: fill = 0;
        OP_INSERT: begin
          if (fill >= Cap) r.status = ST_FULL;
          else if (c.position > fill) r.status = ST_BADPOS;
          else begin
            for (int i = fill; i > c.position; i--) entries[i] = entries[i-1];
            entries[c.position] = c.value;
            fill++;
          end
        end
        OP_UPDATE: begin
          if (c.position >= fill) r.status = ST_BADPOS;
          else entries[c.position] = c.value;
        end
        OP_DELETE: begin
          if (c.position >= fill) r.status = ST_BADPOS;
          else begin
            for (int i = c.position; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
          end
        end
        OP_SORTA, OP_SORTD: begin
          for (int i = 0; i + 1 < fill; i++)
            for (int j = i + 1; j < fill; j++)
              if ((c.opcode == OP_SORTD) ? entries[i] < entries[j]
                                         : entries[j] < entries[i]) begin
                t = entries[i]; entries[i] = entries[j]; entries[j] = t;
              end
        end
        OP_LFIND: begin
          r.status = ST_MISS;
          for (int i = 0; i < fill; i++)
            if (entries[i] == $signed(c.value)) begin
              r.status = ST_OK; r.found_index = i; break;
            end
        end
        OP_BFIND: begin
          r.status = ST_MISS;
          lo = 0; hi = int'(fill) - 1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == $signed(c.value)) begin
              r.status = ST_OK; r.found_index = mid; break;
            end
            if (entries[mid] < $signed(c.value)) lo = mid + 1;
            else hi = mid - 1;
          end
        end
        OP_READ: begin
          if (c.position >= fill) r.status = ST_BADPOS;
          else r.read_data = entries[c.position];
        end
        default: ;
      endcase
      r.count = fill;
      pending.push_back(r);
    endfunction

    function void check_result(res_item_t a);
      res_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d act %0d", e.status, a.status); errors++;
      end
      if (a.found_index !== e.found_index) begin
        $error("found_index exp %0d act %0d", e.found_index, a.found_index); errors++;
      end
      if (a.read_data !== e.read_data) begin
        $error("read_data exp %h act %h", e.read_data, a.read_data); errors++;
      end
      if (a.count !== e.count) begin
        $error("count exp %0d act %0d", e.count, a.count); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  iate_if #(.Width(InW))  cmd_ch ();
  iate_if #(.Width(OutW)) res_ch ();
  list_scoreboard sb = new();
  int idle_cycles = 0;
  bit stall_on = 1'b1;

  always #4 clk_i = ~clk_i;

  indexed_array_table_engine #(.CAPACITY(Cap)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    res_ch.ready = 1'b0;
  end

  // Check results; stall the receiver on its own pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if ($urandom_range(0, 99) == 0) stall_on = ~stall_on;
      res_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("indexed_array_table_engine verification failed");
      $finish;
    end
  end

  // Hand one item over and hold until accepted
  task automatic send_item(input logic [3:0] op, input int unsigned pos,
                           input logic [31:0] val);
    cmd_item_t c;
    c.opcode = op;
    c.position = pos[7:0];
    c.value = val;
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(c);
  endtask

  task automatic pause_sender(input int n);
    cmd_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Pick a position mostly in range, sometimes just past or far past the end
  function automatic int unsigned pick_pos(input int unsigned lim);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom_range(0, 255);
    if (k == 1) return lim;
    return (lim == 0) ? 0 : $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Random item, biased toward meaningful operations
  task automatic random_item();
    int unsigned op, n;
    logic [31:0] v;
    n = sb.fill;
    op = $urandom_range(0, 99);
    v = pick_val();
    if ((op < 40 || op < 50 && sb.fill > 0) && n > 0 && $urandom_range(0, 1))
      v = sb.entries[$urandom_range(0, n - 1)];
    if (op < 30)      send_item(OP_INSERT, pick_pos(n + 1) , v);
    else if (op < 40) send_item(OP_UPDATE, pick_pos(n), v);
    else if (op < 52) send_item(OP_DELETE, pick_pos(n), v);
    else if (op < 60) send_item(OP_LFIND, $urandom_range(0, 255), v);
    else if (op < 70) send_item(OP_BFIND, $urandom_range(0, 255), v);
    else if (op < 84) send_item(OP_READ, pick_pos(n), v);
    else if (op < 87) send_item(OP_SORTA, $urandom_range(0, 255), v);
    else if (op < 89) send_item(OP_SORTD, $urandom_range(0, 255), v);
    else if (op < 90) send_item(OP_CLEAR, $urandom_range(0, 255), v);
    else if (op < 92) send_item($urandom_range(9, 15), $urandom_range(0, 255), v);
    else              send_item(OP_READ, pick_pos(n), v);
  endtask

  initial begin
    int burst;
    bit drained;
    drained = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extremes, duplicates, full table, bad positions
    send_item(OP_SORTA, 0, 0);
    send_item(OP_LFIND, 0, 0);
    send_item(OP_BFIND, 0, 0);
    send_item(OP_READ, 0, 0);
    send_item(OP_DELETE, 0, 0);
    send_item(OP_UPDATE, 0, 0);
    send_item(OP_INSERT, 1, 5);
    send_item(OP_INSERT, 0, 32'h7fff_ffff);
    send_item(OP_INSERT, 0, 32'h8000_0000);
    send_item(OP_INSERT, 1, 32'hffff_ffff);
    send_item(OP_INSERT, 3, 32'hffff_ffff);
    send_item(OP_LFIND, 255, 32'hffff_ffff);
    send_item(OP_BFIND, 0, 32'hffff_ffff);
    send_item(OP_SORTD, 0, 0);
    send_item(OP_BFIND, 0, 32'h8000_0000);
    send_item(OP_SORTA, 0, 0);
    send_item(OP_BFIND, 0, 32'h7fff_ffff);
    send_item(OP_UPDATE, 2, 32'h5555_aaaa);
    send_item(OP_READ, 2, 0);
    send_item(OP_READ, 255, 0);
    send_item(OP_DELETE, 0, 0);
    send_item(4'hf, 8'hff, 32'hffff_ffff);
    send_item(OP_CLEAR, 0, 0);
    for (int i = 0; i < Cap; i++) send_item(OP_INSERT, i, $urandom());
    send_item(OP_INSERT, 0, 1);
    send_item(OP_INSERT, 200, 1);
    send_item(OP_READ, Cap - 1, 0);
    send_item(OP_DELETE, Cap - 1, 0);
    send_item(OP_CLEAR, 0, 0);

    // Random: refills, bursts and gaps, one full drain midway
    for (int k = 0; k < 850; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, k++) begin
        if (sb.fill == 0 && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(2, 12))
            send_item(OP_INSERT, $urandom_range(0, sb.fill), pick_val());
        random_item();
      end
      if (k > 400 && !drained) begin
        drained = 1'b1;
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 20));
    end
    cmd_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("indexed_array_table_engine verification clean");
    else $display("indexed_array_table_engine verification failed");
    $finish;
  end
endmodule

// File: filelist.f
src/iate_pkg.sv
src/iate_if.sv
src/iate_ram.sv
src/iate_ctrl.sv
src/iate_dp.sv
src/indexed_array_table_engine.sv
verif/indexed_array_table_engine_tb.sv
